FILE: hdl/ttlb_pkg.sv
// Shared types and character codes for the text terminal line buffer.
`timescale 1ns / 1ps
`default_nettype none

package ttlb_pkg;

  localparam int CHAR_W    = 8;
  localparam int IN_ROW_W  = 3;
  localparam int IN_COL_W  = 5;
  localparam int OUT_ROW_W = 3;
  localparam int OUT_COL_W = 5;
  localparam int OUT_LEN_W = 5;

  localparam logic CMD_PUT   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CHAR_W-1:0] CODE_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

  // per-row controls for one accepted request
  typedef struct packed {
    logic write;   // store a byte into this row
    logic scroll;  // take the row below (after its write)
    logic blank;   // row becomes empty after the move
  } row_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/ttlb_if.sv
// Request and result channel interfaces of the text terminal line buffer.
`timescale 1ns / 1ps
`default_nettype none

interface ttlb_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;
  logic [2:0] read_row;
  logic [4:0] read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface ttlb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cursor_row;
  logic [4:0] cursor_col;
  logic [7:0] cell_char;
  logic [4:0] row_length;

  modport source (output valid, cursor_row, cursor_col, cell_char, row_length, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_char, row_length, output ready);
endinterface

`default_nettype wire

FILE: hdl/ttlb_row_cell.sv
// One visible terminal row: its bytes, its length and the shift from the row below.
`timescale 1ns / 1ps
`default_nettype none

module ttlb_row_cell #(
  parameter int COLUMNS = 21,
  parameter int COL_W   = 5,
  parameter int IDX_W   = 5
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire ttlb_pkg::row_ctl_t ctl,
  input  wire [IDX_W-1:0]         wr_col,
  input  wire [COL_W-1:0]         wr_len,
  input  wire [7:0]               wr_data,
  input  wire [COLUMNS-1:0][7:0]  shift_bytes,
  input  wire [COL_W-1:0]         shift_len,
  output logic [COLUMNS-1:0][7:0] post_bytes,
  output logic [COL_W-1:0]        post_len,
  input  wire [4:0]               read_col,
  output logic [7:0]              rd_char,
  output logic [COL_W-1:0]        rd_len
);

  localparam int CMP_W = (COL_W > 5) ? COL_W : 5;

  logic [COLUMNS-1:0][7:0] bytes;
  logic [COLUMNS-1:0][7:0] bytes_next;
  logic [COL_W-1:0]        len;
  logic [COL_W-1:0]        len_next;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_hit;

  always_comb begin
    post_bytes = bytes;
    post_len   = len;
    if (ctl.write) begin
      post_bytes[wr_col] = wr_data;
      post_len           = wr_len;
    end
    // write lands first, then the whole row moves up on a scroll
    bytes_next = ctl.scroll ? shift_bytes : post_bytes;
    len_next   = ctl.scroll ? shift_len : post_len;
    if (ctl.blank) begin
      len_next = '0;
    end
  end

  // result reflects the state after this request
  always_comb begin
    rd_idx  = IDX_W'(read_col);
    rd_hit  = CMP_W'(read_col) < CMP_W'(len_next);
    rd_char = rd_hit ? bytes_next[rd_idx] : 8'd0;
    rd_len  = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    bytes <= bytes_next;
  end

endmodule

`default_nettype wire

FILE: hdl/text_terminal_line_buffer.sv
// Text terminal line buffer: a chain of row cells with cursor control and a result register.
// Usage:
//   in  : one request per handshake (valid && ready): command (0 put, 1 clear),
//         char_code, and the visible cell (read_row, read_col) to report.
//   out : one result per request: cursor after the request, the requested
//         byte (0 at or past the row length) and that row's length.
// Result register: the result is registered in the output register when its request
//   is taken; the state update and the cell read happen in that same cycle.
// Throughput: one request per cycle unless stalled; every row cell updates in the same
//   cycle, and a scroll moves each row into the cell above it, so no pointer is kept.
// Stall: while a result waits in the output register and out.ready is low,
//   in.ready is low; when out.ready is high a new request is taken in the
//   same cycle that the waiting result leaves.
// Reset: synchronous, active high; all rows empty, cursor at home, output
//   register empty. Stored bytes are not cleared; a row only reports bytes
//   below its length, which were always written.
// Clear: empties every row and homes the cursor.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_line_buffer #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 21
) (
  input wire         clk,
  input wire         rst,
  ttlb_in_if.sink    in,
  ttlb_out_if.source out
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [ROW_W-1:0] cr;
  logic [ROW_W-1:0] cr_next;
  logic [COL_W-1:0] cc;
  logic [COL_W-1:0] cc_next;
  logic [ROW_W-1:0] cr_inc;
  logic [COL_W-1:0] cc_inc;
  logic             accept;
  logic             do_write;
  logic             do_newline;
  logic             do_clear;
  logic             at_bottom;
  logic [7:0]       wr_data;

  ttlb_pkg::row_ctl_t      ctl        [ROWS];
  logic [COLUMNS-1:0][7:0] post_bytes [ROWS];
  logic [COL_W-1:0]        post_len   [ROWS];
  logic [7:0]              rd_char    [ROWS];
  logic [COL_W-1:0]        rd_len     [ROWS];

  logic [7:0]       sel_char;
  logic [COL_W-1:0] sel_len;

  assign in.ready = !out.valid || out.ready;
  assign accept   = in.valid && in.ready;

  assign cr_inc    = cr + 1'b1;
  assign cc_inc    = cc + 1'b1;
  assign at_bottom = (cr == ROW_W'(ROWS - 1));

  // request decode and cursor update
  always_comb begin
    do_write   = 1'b0;
    do_newline = 1'b0;
    do_clear   = 1'b0;
    wr_data    = (in.char_code == ttlb_pkg::CODE_TAB) ? ttlb_pkg::CODE_SPACE : in.char_code;
    cr_next    = cr;
    cc_next    = cc;
    if (accept) begin
      if (in.command == ttlb_pkg::CMD_CLEAR) begin
        do_clear = 1'b1;
        cr_next  = '0;
        cc_next  = '0;
      end else begin
        case (in.char_code)
          ttlb_pkg::CODE_CR, ttlb_pkg::CODE_NUL: begin
          end
          ttlb_pkg::CODE_LF: begin
            do_newline = 1'b1;
          end
          default: begin
            do_write = 1'b1;
            cc_next  = cc_inc;
            // wrap as soon as the column limit is reached
            if (cc_inc == COL_W'(COLUMNS)) begin
              do_newline = 1'b1;
            end
          end
        endcase
        if (do_newline) begin
          cr_next = at_bottom ? cr : cr_inc;
          cc_next = '0;
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      ctl[r].write  = do_write && (cr == ROW_W'(r));
      ctl[r].scroll = do_newline && at_bottom;
      ctl[r].blank  = do_clear || (do_newline && (cr_next == ROW_W'(r)));
    end
  end

  for (genvar g = 0; g < ROWS; g++) begin : g_row
    localparam int NB = (g == ROWS - 1) ? g : g + 1;

    ttlb_row_cell #(
      .COLUMNS (COLUMNS),
      .COL_W   (COL_W),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[g]),
      .wr_col      (cc[IDX_W-1:0]),
      .wr_len      (cc_inc),
      .wr_data     (wr_data),
      .shift_bytes (post_bytes[NB]),
      .shift_len   (post_len[NB]),
      .post_bytes  (post_bytes[g]),
      .post_len    (post_len[g]),
      .read_col    (in.read_col),
      .rd_char     (rd_char[g]),
      .rd_len      (rd_len[g])
    );
  end

  // requested row; rows past the last one report zero
  always_comb begin
    sel_char = 8'd0;
    sel_len  = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (32'(in.read_row) == r) begin
        sel_char = rd_char[r];
        sel_len  = rd_len[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr        <= '0;
      cc        <= '0;
      out.valid <= 1'b0;
    end else begin
      cr <= cr_next;
      cc <= cc_next;
      if (accept) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out.cursor_row <= ttlb_pkg::OUT_ROW_W'(cr_next);
      out.cursor_col <= ttlb_pkg::OUT_COL_W'(cc_next);
      out.cell_char  <= sel_char;
      out.row_length <= ttlb_pkg::OUT_LEN_W'(sel_len);
    end
  end

  a_col_below_limit: assert property (@(posedge clk) disable iff (rst)
    32'(cc) < COLUMNS)
    else $error("cursor column reached the column limit");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    accept && (in.command == ttlb_pkg::CMD_CLEAR)
    |=> (out.cursor_row == '0) && (out.cursor_col == '0) && (out.row_length == '0))
    else $error("clear did not home the cursor and empty the rows");

  a_lf_advances: assert property (@(posedge clk) disable iff (rst)
    accept && (in.command == ttlb_pkg::CMD_PUT) && (in.char_code == ttlb_pkg::CODE_LF)
    && !at_bottom |=> (cr == $past(cr_inc)) && (cc == '0))
    else $error("line feed did not move to the next row");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (32'(out.row_length) <= COLUMNS))
    else $error("row length above the column limit");

endmodule

`default_nettype wire

FILE: tb/ttlb_checker.sv
// Scoreboard for the terminal line buffer: models the screen and checks every result.
`timescale 1ns / 1ps

module ttlb_checker #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 21
) (
  input  logic clk,
  input  logic rst,
  ttlb_in_if   req,
  ttlb_out_if  res,
  output int   mismatches,
  output int   outstanding
);
  import ttlb_pkg::*;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [CHAR_W-1:0]    cell_char;
    logic [OUT_LEN_W-1:0] row_length;
  } screen_report_t;

  // screen model, indexed by physical row
  logic [CHAR_W-1:0]    screen [ROWS][COLUMNS];
  logic [OUT_LEN_W-1:0] fill   [ROWS];
  int unsigned          top_ptr;
  int unsigned          cur_row;
  int unsigned          cur_col;

  screen_report_t screen_reports_due [$];

  function automatic int unsigned phys_of(int unsigned vis);
    int unsigned p;
    p = top_ptr + vis;
    if (p >= ROWS) p -= ROWS;
    return p;
  endfunction

  // line feed or wrap; scrolling is a move of the top pointer
  function automatic void start_new_row();
    if (cur_row >= ROWS - 1) begin
      top_ptr = phys_of(1);
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
    cur_col = 0;
    fill[phys_of(cur_row)] = '0;
  endfunction

  function automatic void place_char(logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    int unsigned       p;
    c = code;
    if (c == CODE_CR || c == CODE_NUL) return;
    if (c == CODE_LF) begin
      start_new_row();
      return;
    end
    if (c == CODE_TAB) c = CODE_SPACE;
    if (cur_col >= COLUMNS) start_new_row();
    p = phys_of(cur_row);
    screen[p][cur_col] = c;
    cur_col++;
    fill[p] = OUT_LEN_W'(cur_col);
    if (cur_col >= COLUMNS) start_new_row();
  endfunction

  function automatic screen_report_t predict_terminal(logic cmd, logic [CHAR_W-1:0] code,
                                                      logic [IN_ROW_W-1:0] rrow,
                                                      logic [IN_COL_W-1:0] rcol);
    screen_report_t r;
    int unsigned    p;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < ROWS; i++) fill[i] = '0;
      top_ptr = 0;
      cur_row = 0;
      cur_col = 0;
    end else begin
      place_char(code);
    end
    r.cursor_row = OUT_ROW_W'(cur_row);
    r.cursor_col = OUT_COL_W'(cur_col);
    r.cell_char  = '0;
    r.row_length = '0;
    if (rrow < ROWS) begin
      p = phys_of(rrow);
      r.row_length = fill[p];
      if (rcol < fill[p]) r.cell_char = screen[p][rcol];
    end
    return r;
  endfunction

  function automatic void note_failure(string what);
    if (mismatches < 10) $display("%0t: %s", $realtime, what);
    mismatches++;
  endfunction

  initial begin
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < COLUMNS; j++) screen[i][j] = '0;
    end
  end

  always @(posedge clk) begin
    screen_report_t want;
    screen_report_t got;
    if (rst) begin
      for (int i = 0; i < ROWS; i++) fill[i] = '0;
      top_ptr = 0;
      cur_row = 0;
      cur_col = 0;
      screen_reports_due.delete();
      mismatches = 0;
    end else begin
      // results are taken before requests: a result never answers a same-edge request
      if (res.valid && res.ready) begin
        got.cursor_row = res.cursor_row;
        got.cursor_col = res.cursor_col;
        got.cell_char  = res.cell_char;
        got.row_length = res.row_length;
        if (screen_reports_due.size() == 0) begin
          note_failure($sformatf("result with none due: row %0d col %0d char %0d len %0d",
                                 got.cursor_row, got.cursor_col, got.cell_char,
                                 got.row_length));
        end else begin
          want = screen_reports_due.pop_front();
          if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
              got.cell_char !== want.cell_char || got.row_length !== want.row_length) begin
            note_failure($sformatf(
              "mismatch: cursor %0d,%0d char %0d len %0d, expected cursor %0d,%0d char %0d len %0d",
              got.cursor_row, got.cursor_col, got.cell_char, got.row_length,
              want.cursor_row, want.cursor_col, want.cell_char, want.row_length));
          end
        end
      end
      if (req.valid && req.ready) begin
        screen_reports_due.push_back(predict_terminal(req.command, req.char_code,
                                                      req.read_row, req.read_col));
      end
    end
    outstanding = screen_reports_due.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the terminal line buffer bench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module testbench;
  import ttlb_pkg::*;

  localparam int ROWS        = 8;
  localparam int COLUMNS     = 21;
  localparam int ITEMS       = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN       = 10;

  logic clk;
  logic rst;
  int   bad_reports;
  int   reports_due;
  int   sent_count;
  bit   calm;

  ttlb_in_if  req_ch ();
  ttlb_out_if res_ch ();

  text_terminal_line_buffer #(.ROWS(ROWS), .COLUMNS(COLUMNS)) dut (
    .clk (clk),
    .rst (rst),
    .in  (req_ch),
    .out (res_ch)
  );

  ttlb_checker #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .mismatches  (bad_reports),
    .outstanding (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic cmd, input logic [CHAR_W-1:0] code,
                              input logic [IN_ROW_W-1:0] row, input logic [IN_COL_W-1:0] col);
    calm = (sent_count >= 600 && sent_count < 800);
    while (!calm && $urandom_range(0, 99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.char_code <= code;
    req_ch.read_row  <= row;
    req_ch.read_col  <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] code);
    send_request(CMD_PUT, code, IN_ROW_W'($urandom_range(0, ROWS - 1)),
                 IN_COL_W'($urandom_range(0, COLUMNS - 1)));
  endtask

  task automatic send_clear();
    send_request(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                 IN_ROW_W'($urandom_range(0, ROWS - 1)),
                 IN_COL_W'($urandom_range(0, COLUMNS - 1)));
  endtask

  initial begin
    int                run;
    int                pick;
    int                flavor;
    bit                paused;
    logic [CHAR_W-1:0] code;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_PUT;
    req_ch.char_code = '0;
    req_ch.read_row  = '0;
    req_ch.read_col  = '0;
    sent_count       = 0;
    calm             = 1'b0;
    paused           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored codes, tab, extremes, line feeds through a scroll, clear
    send_request(CMD_CLEAR, 8'hFF, 3'd7, 5'd20);
    send_request(CMD_PUT, 8'h41, 3'd0, 5'd0);
    send_request(CMD_PUT, 8'hFF, 3'd0, 5'd1);
    send_request(CMD_PUT, CODE_NUL, 3'd0, 5'd1);
    send_request(CMD_PUT, CODE_CR, 3'd0, 5'd0);
    send_request(CMD_PUT, CODE_TAB, 3'd0, 5'd2);
    send_request(CMD_PUT, 8'h01, 3'd0, 5'd3);
    send_request(CMD_PUT, CODE_LF, 3'd0, 5'd2);
    send_request(CMD_PUT, 8'h42, 3'd1, 5'd0);
    for (int i = 0; i < 8; i++) begin
      send_request(CMD_PUT, CODE_LF, IN_ROW_W'(7 - i), IN_COL_W'(i == 7 ? 20 : i));
    end
    send_request(CMD_PUT, 8'h43, 3'd7, 5'd0);
    send_request(CMD_PUT, 8'h7E, 3'd0, 5'd0);
    send_request(CMD_CLEAR, 8'h00, 3'd7, 5'd0);
    send_request(CMD_PUT, 8'h80, 3'd0, 5'd16);
    send_request(CMD_PUT, 8'h7F, 3'd0, 5'd1);

    // random: mostly text lines of random length (crossing wraps), some noise and clears
    while (sent_count < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_clear();
      end else if (pick < 8) begin
        send_put(CHAR_W'($urandom_range(0, 255)));
      end else begin
        run = $urandom_range(0, 30);
        for (int i = 0; i < run && sent_count < ITEMS; i++) begin
          flavor = $urandom_range(0, 19);
          if (flavor == 0) begin
            code = CODE_TAB;
          end else if (flavor == 1) begin
            code = CHAR_W'($urandom_range(128, 255));
          end else begin
            code = CHAR_W'($urandom_range(32, 126));
          end
          send_put(code);
        end
        flavor = $urandom_range(0, 19);
        if (flavor < 3) begin
          send_put(CODE_CR);
          send_put(CODE_LF);
        end else if (flavor < 17) begin
          send_put(CODE_LF);
        end
      end
      if (!paused && sent_count >= 500) begin
        // let the block drain completely before going on
        paused = 1'b1;
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (reports_due != 0) @(negedge clk);
      end
    end

    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (bad_reports == 0 && reports_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random back-pressure plus one long hold-off while requests keep coming
  initial begin
    int hold_left;
    bit held;
    res_ch.ready = 1'b0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 200) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // watchdog: cycles without any accepted request or result
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule
